// ===== sv/sha_pkg.sv =====
// Package of shared types, constants and round tables for the SHA-256 digest unit.
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       store_word;   // write req data at the fill position
      logic       store_pad;    // write the padding word at the fill position
      logic       zero_word;    // write zero at the fill position
      logic       store_len;    // write the length words into positions 14 and 15
      logic       start_block;  // load working variables from the chain value
      logic       do_round;     // run one round
      logic       fold;         // add working variables into the chain value
      logic       reset_chain;  // chain value back to the initial vector
      logic       clear_len;    // message length and fill back to zero
      logic       emit_load;    // load the output register with digest word
      logic [2:0] emit_index;
   } cmd_type;

   typedef struct packed {
      logic [3:0] fill_word;    // current word position
      logic       last_round;   // round 63 under way
   } status_type;

   localparam logic [31:0] PAD_BYTE = 32'h0000_0080;

   function automatic logic [31:0] init_vec(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
   };

endpackage

// ===== sv/sha_datapath.sv =====
// Datapath of the SHA-256 digest unit: schedule, working variables, chain value, length.
module sha_datapath (
   input  logic              clock,
   input  logic              reset,
   input  sha_pkg::cmd_type  cmd,
   input  logic [31:0]       req_word,
   input  logic [2:0]        req_count,
   input  logic              req_last,
   output sha_pkg::status_type status,
   output logic [31:0]       out_word
);

   logic [31:0] sched_ff [16];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [31:0] chain_ff [8];
   logic [5:0]  fill_ff;
   logic [60:0] len_ff;
   logic [60:0] len_in;
   logic [5:0]  round_ff;
   logic [31:0] out_ff;
   logic [2:0]  cnt_sat;
   logic [31:0] pad_word;
   logic [31:0] keep;
   logic [31:0] w_cur, x15, x2, g0, g1, s0, s1, ch, maj, t1, t2;
   logic [3:0]  ri;
   logic [63:0] bit_len;

   always_comb begin
      cnt_sat = (req_count > 3'd4) ? 3'd4 : req_count;
      if (!req_last) cnt_sat = 3'd4;
      case (cnt_sat)
         3'd0: keep = 32'h0;
         3'd1: keep = 32'hff00_0000;
         3'd2: keep = 32'hffff_0000;
         3'd3: keep = 32'hffff_ff00;
         default: keep = 32'hffff_ffff;
      endcase
      // The marker byte follows the kept bytes; a full last word gets it in the next word.
      pad_word = (req_word & keep) |
                 ((cnt_sat == 3'd4) ? 32'h0 : (sha_pkg::PAD_BYTE << (6'd24 - 6'(cnt_sat) * 6'd8)));
      len_in = len_ff + 61'(cnt_sat);
      bit_len = {len_ff, 3'b000};
   end

   always_comb begin
      ri  = round_ff[3:0];
      x15 = sched_ff[ri + 4'd1];
      x2  = sched_ff[ri + 4'd14];
      g0  = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
      g1  = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
      w_cur = (round_ff < 6'd16) ? sched_ff[ri] : sched_ff[ri] + g0 + sched_ff[ri + 4'd9] + g1;
      s1 = {work_ff[4][5:0], work_ff[4][31:6]} ^ {work_ff[4][10:0], work_ff[4][31:11]} ^
           {work_ff[4][24:0], work_ff[4][31:25]};
      ch = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1 = work_ff[7] + s1 + ch + sha_pkg::ROUND_K[round_ff] + w_cur;
      s0 = {work_ff[0][1:0], work_ff[0][31:2]} ^ {work_ff[0][12:0], work_ff[0][31:13]} ^
           {work_ff[0][21:0], work_ff[0][31:22]};
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t2 = s0 + maj;
      work_in[7] = work_ff[6];
      work_in[6] = work_ff[5];
      work_in[5] = work_ff[4];
      work_in[4] = work_ff[3] + t1;
      work_in[3] = work_ff[2];
      work_in[2] = work_ff[1];
      work_in[1] = work_ff[0];
      work_in[0] = t1 + t2;
   end

   always_ff @(posedge clock) begin
      if (cmd.store_word) sched_ff[fill_ff[5:2]] <= req_last ? pad_word : req_word;
      else if (cmd.store_pad) sched_ff[fill_ff[5:2]] <= 32'h8000_0000;
      else if (cmd.zero_word) sched_ff[fill_ff[5:2]] <= 32'h0;
      else if (cmd.store_len) begin
         sched_ff[14] <= bit_len[63:32];
         sched_ff[15] <= bit_len[31:0];
      end else if (cmd.do_round && round_ff >= 6'd16) sched_ff[ri] <= w_cur;
      if (cmd.start_block) begin
         for (int i = 0; i < 8; i++) work_ff[i] <= chain_ff[i];
      end else if (cmd.do_round) begin
         for (int i = 0; i < 8; i++) work_ff[i] <= work_in[i];
      end
      if (cmd.emit_load) out_ff <= chain_ff[cmd.emit_index];
      if (reset) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= sha_pkg::init_vec(3'(i));
         fill_ff  <= '0;
         len_ff   <= '0;
         round_ff <= '0;
      end else begin
         if (cmd.reset_chain) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= sha_pkg::init_vec(3'(i));
         end else if (cmd.fold) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
         end
         if (cmd.store_word) len_ff <= len_in;
         if (cmd.clear_len) begin
            len_ff  <= '0;
            fill_ff <= '0;
         end else if (cmd.store_word || cmd.store_pad || cmd.zero_word) begin
            fill_ff <= fill_ff + 6'd4;
         end else if (cmd.store_len) begin
            fill_ff <= '0;
         end
         if (cmd.do_round) round_ff <= round_ff + 6'd1;
      end
   end

   assign status.fill_word  = fill_ff[5:2];
   assign status.last_round = (round_ff == 6'd63);
   assign out_word = out_ff;

endmodule

// ===== sv/sha_control.sv =====
// Controller state machine of the SHA-256 digest unit.
module sha_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          req_count,
   input  logic                req_last,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [2:0]          rsp_index,
   input  sha_pkg::status_type status,
   output sha_pkg::cmd_type    cmd
);

   sha_pkg::state_type state_ff, state_in;
   logic        final_ff, final_in;   // message closes after this block
   logic        padq_ff, padq_in;     // marker word still to be written
   logic        fillwrap_ff, fillwrap_in;
   logic [3:0]  emit_ff, emit_in;     // digest words loaded so far
   logic        valid_ff, valid_in;
   logic [2:0]  idx_ff;
   logic        take;
   logic        load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha_pkg::ST_IDLE;
         final_ff    <= 1'b0;
         padq_ff     <= 1'b0;
         fillwrap_ff <= 1'b0;
         emit_ff     <= '0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         final_ff    <= final_in;
         padq_ff     <= padq_in;
         fillwrap_ff <= fillwrap_in;
         emit_ff     <= emit_in;
         valid_ff    <= valid_in;
      end
      if (load) idx_ff <= emit_ff[2:0];
   end

   always_comb begin
      state_in    = state_ff;
      final_in    = final_ff;
      padq_in     = padq_ff;
      fillwrap_in = fillwrap_ff;
      emit_in     = emit_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      take        = 1'b0;
      load        = 1'b0;
      valid_in    = valid_ff && !rsp_tready;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            take = req_tvalid;
            if (take) begin
               cmd.store_word = 1'b1;
               fillwrap_in = (status.fill_word == 4'd15);
               if (req_last) begin
                  final_in = 1'b1;
                  padq_in = (req_count >= 3'd4);
                  state_in = (status.fill_word == 4'd15) ? sha_pkg::ST_ROUND
                                                         : sha_pkg::ST_PAD;
                  if (status.fill_word == 4'd15) cmd.start_block = 1'b0;
               end else if (status.fill_word == 4'd15) begin
                  state_in = sha_pkg::ST_ROUND;
               end
            end
         end
         sha_pkg::ST_PAD: begin
            // Fill the block with the marker and zeros up to the length words.
            if (padq_ff) begin
               cmd.store_pad = 1'b1;
               padq_in = 1'b0;
               if (status.fill_word == 4'd15) state_in = sha_pkg::ST_ROUND;
            end else if (status.fill_word == 4'd14) begin
               cmd.store_len = 1'b1;
               final_in = 1'b0;
               emit_in = 4'd8;
               state_in = sha_pkg::ST_ROUND;
            end else if (status.fill_word == 4'd15) begin
               cmd.zero_word = 1'b1;
               state_in = sha_pkg::ST_ROUND;
            end else begin
               cmd.zero_word = 1'b1;
            end
         end
         sha_pkg::ST_ROUND: begin
            if (fillwrap_ff) begin
               cmd.start_block = 1'b1;
               fillwrap_in = 1'b0;
            end else begin
               cmd.do_round = 1'b1;
               if (status.last_round) state_in = sha_pkg::ST_ADD;
            end
         end
         sha_pkg::ST_ADD: begin
            cmd.fold = 1'b1;
            if (emit_ff == 4'd8) begin
               emit_in = 4'd0;
               state_in = sha_pkg::ST_EMIT;
            end else if (final_ff) begin
               state_in = sha_pkg::ST_PAD;
            end else begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         sha_pkg::ST_EMIT: begin
            if (!valid_ff || rsp_tready) begin
               load = 1'b1;
               cmd.emit_load = 1'b1;
               cmd.emit_index = emit_ff[2:0];
               valid_in = 1'b1;
               emit_in = emit_ff + 4'd1;
               if (emit_ff == 4'd7) begin
                  // The word count goes back to zero so that later blocks are not taken as closing ones.
                  emit_in = 4'd0;
                  cmd.reset_chain = 1'b1;
                  cmd.clear_len = 1'b1;
                  state_in = sha_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
      // Every block entry goes through a load of the working variables first.
      if (state_in == sha_pkg::ST_ROUND && state_ff != sha_pkg::ST_ROUND) fillwrap_in = 1'b1;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_index  = idx_ff;

   ap_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sha_pkg::ST_IDLE) |-> !req_tready) else $error("item taken while busy");
   ap_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sha_pkg::ST_ADD) |-> $past(status.last_round)) else $error("short block");
   ap_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_index)))
      else $error("result dropped");

endmodule

// ===== sv/sha256_message_digest_unit.sv =====
// Top level of the SHA-256 digest unit.
// req channel: one item is a big-endian message word with a byte count and
// tlast for the final word of the message. Words that are not last carry all
// four bytes. The rsp channel gives the eight digest words, h0 first, tuser
// holding the word position and tlast marking the eighth.
// Each sixteenth word starts a 64-round compression of one round per cycle,
// and no new word is taken until the block is folded into the chain value.
// The last word adds padding (one zero word at a time), one or two closing
// blocks and then the eight digest words on the rsp channel.
// While the round loop or the padding runs, req_tready is low.
// A stalled receiver holds the current digest word in the output register and
// the emission waits; the next message is taken once all eight have left the
// controller. Reset returns the chain value to the initial vector and clears
// the length and fill counts; the message schedule is not cleared.
// After the eighth word the unit is ready for a fresh message.
module sha256_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_word [31:0], byte_count [34:32], zeros
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word [31:0]
   output logic [2:0]  rsp_tuser,   // word_index [2:0]
   output logic        rsp_tlast
);

   sha_pkg::cmd_type    cmd;
   sha_pkg::status_type status;

   sha_control u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_count (req_tdata[34:32]), .req_last (req_tlast),
      .rsp_tvalid, .rsp_tready, .rsp_index (rsp_tuser),
      .status, .cmd
   );

   sha_datapath u_dp (
      .clock, .reset, .cmd,
      .req_word (req_tdata[31:0]), .req_count (req_tdata[34:32]), .req_last (req_tlast),
      .status, .out_word (rsp_tdata)
   );

   assign rsp_tlast = (rsp_tuser == 3'd7);

endmodule

// ===== tb/sha256_digest_checker.sv =====
// Checker for the SHA-256 digest unit: predicts digests from accepted words and compares results.
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          failures,
   output int          pending,
   output int          digests_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_result_type;

   localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
      32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   digest_result_type expected_digests[$];
   logic [31:0] hash_state[8];
   logic [31:0] block_words[16];
   int          fill_bytes;
   logic [60:0] byte_total;

   function automatic logic [31:0] ror(input logic [31:0] v, input int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   task automatic compress();
      logic [31:0] v[8];
      logic [31:0] w, x15, x2, t1, t2;
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int r = 0; r < 64; r++) begin
         if (r < 16) begin
            w = block_words[r];
         end else begin
            x15 = block_words[(r - 15) & 15];
            x2 = block_words[(r - 2) & 15];
            w = block_words[r & 15] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3))
               + block_words[(r - 7) & 15] + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
            block_words[r & 15] = w;
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[r] + w;
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic append_word(input logic [31:0] w);
      block_words[fill_bytes / 4] = w;
      fill_bytes += 4;
      if (fill_bytes >= 64) begin
         compress();
         fill_bytes = 0;
      end
   endtask

   task automatic absorb_item(input logic [31:0] data, input logic [2:0] count,
                              input logic is_last);
      int          n;
      int          pos;
      logic [31:0] keep;
      logic [63:0] bit_len;
      digest_result_type res;
      if (!is_last) begin
         byte_total += 4;
         append_word(data);
      end else begin
         n = (count > 4) ? 4 : count;
         byte_total += n;
         if (n == 4) begin
            append_word(data);
            append_word(32'h8000_0000);
         end else begin
            keep = (n == 0) ? 32'h0 : ~(32'hffff_ffff >> (8 * n));
            append_word((data & keep) | (32'h80 << (24 - 8 * n)));
         end
         pos = fill_bytes / 4;
         if (pos > 14) begin
            for (int i = pos; i < 16; i++) block_words[i] = '0;
            compress();
            pos = 0;
         end
         for (int i = pos; i < 14; i++) block_words[i] = '0;
         bit_len = {byte_total, 3'b000};
         block_words[14] = bit_len[63:32];
         block_words[15] = bit_len[31:0];
         compress();
         for (int i = 0; i < 8; i++) begin
            res.digest_word = hash_state[i];
            res.word_index = 3'(i);
            res.last_word = (i == 7);
            expected_digests = {expected_digests, res};
         end
         for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
         fill_bytes = 0;
         byte_total = '0;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] digest mismatch: %s", $realtime, what);
      failures++;
   endtask

   initial begin
      failures = 0;
      digests_seen = 0;
      for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
      fill_bytes = 0;
      byte_total = '0;
   end

   assign pending = expected_digests.size();

   always @(posedge clock) begin
      digest_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            absorb_item(req_tdata[31:0], req_tdata[34:32], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            digests_seen++;
            if (expected_digests.size() == 0) begin
               report_mismatch($sformatf("unexpected item %h", rsp_tdata));
            end else begin
               want = expected_digests.pop_front();
               if (rsp_tdata !== want.digest_word)
                  report_mismatch($sformatf("word %0d got %h want %h", want.word_index,
                                            rsp_tdata, want.digest_word));
               if (rsp_tuser !== want.word_index)
                  report_mismatch($sformatf("index got %0d want %0d", rsp_tuser,
                                            want.word_index));
               if (rsp_tlast !== want.last_word)
                  report_mismatch($sformatf("tlast got %b want %b", rsp_tlast,
                                            want.last_word));
            end
         end
      end
   end
endmodule

// ===== tb/sha256_message_digest_unit_test.sv =====
// Testbench top for the SHA-256 digest unit: stimulus, stalls, watchdog and verdict.
module sha256_message_digest_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   int          failures, pending, digests_seen;
   int          items_sent = 0;
   int          messages_sent = 0;
   int          quiet_cycles = 0;
   bit          stall_pattern = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sha256_message_digest_unit uut (.*);

   sha256_digest_checker checker_i (.*);

   // Receiver stalls: alternate between free flow and random back-pressure.
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_pattern <= ~stall_pattern;
      rsp_tready <= stall_pattern ? ($urandom_range(0, 3) == 0) : 1'b1;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("sha256_message_digest_unit regression: fail");
            $finish;
         end
      end
   end

   // Presents one word and holds it until accepted; gaps only between bursts.
   task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                            input logic is_last);
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, count, data};
      req_tlast <= is_last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (is_last) messages_sent++;
      if ($urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Message of the given number of full words, closed by a last word.
   task automatic send_message(input int full_words, input logic [2:0] tail_count,
                               input bit random_data);
      for (int i = 0; i < full_words; i++)
         send_word(random_data ? $urandom : 32'hffff_ffff, 3'($urandom_range(0, 7)), 1'b0);
      send_word(random_data ? $urandom : 32'hffff_ffff, tail_count, 1'b1);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: empty message, all tail counts, oversized counts, zero data.
      send_word(32'h0, 3'd0, 1'b1);
      send_word(32'h6162_6300, 3'd3, 1'b1);
      send_word(32'hffff_ffff, 3'd4, 1'b1);
      send_word(32'hffff_ffff, 3'd7, 1'b1);
      send_word(32'hffff_ffff, 3'd5, 1'b1);
      send_word(32'h0000_0000, 3'd4, 1'b1);
      send_word(32'hffff_ffff, 3'd1, 1'b1);
      send_word(32'hffff_ffff, 3'd2, 1'b1);
      // Tail lands near the length field, forcing an extra closing block.
      send_message(13, 3'd4, 1'b0);
      send_message(15, 3'd0, 1'b1);
      // Random messages, mostly short, a few spanning several blocks.
      while (items_sent < 230) begin
         if ($urandom_range(0, 7) == 0)
            send_message($urandom_range(16, 40), 3'($urandom_range(0, 7)), 1'b1);
         else
            send_message($urandom_range(0, 17), 3'($urandom_range(0, 7)), 1'b1);
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d words in %0d messages", items_sent, messages_sent);
      $display("checked %0d digest words", digests_seen);
      if (failures == 0 && pending == 0)
         $display("sha256_message_digest_unit regression: pass");
      else
         $display("sha256_message_digest_unit regression: fail");
      $finish;
   end
endmodule

// ===== sha256_message_digest_unit.f =====
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_control.sv
sv/sha256_message_digest_unit.sv
tb/sha256_digest_checker.sv
tb/sha256_message_digest_unit_test.sv
